// ===== design/hst_pkg.sv =====
package hst_pkg;

  // request opcodes
  localparam logic [2:0] OP_ALLOC_REF    = 3'd0;
  localparam logic [2:0] OP_INSTALL_TAKE = 3'd1;
  localparam logic [2:0] OP_INSTALL_AT   = 3'd2;
  localparam logic [2:0] OP_GET          = 3'd3;
  localparam logic [2:0] OP_CLOSE        = 3'd4;
  localparam logic [2:0] OP_DUP          = 3'd5;
  localparam logic [2:0] OP_DUP2         = 3'd6;
  localparam logic [2:0] OP_COUNT        = 3'd7;

  // result status codes
  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_INVALID  = 2'd1;
  localparam logic [1:0] STATUS_TOO_MANY = 2'd2;

  // width of one slot group for the lowest free search
  localparam int unsigned GRP   = 16;
  localparam int unsigned GRP_W = 4;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [31:0] object_handle;
    logic [7:0]  index_a;
    logic [7:0]  index_b;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  slot_index;
    logic [31:0] found_handle;
    logic [8:0]  open_count;
    logic [31:0] ref_handle;
    logic [31:0] unref_handle;
  } rsp_t;

endpackage

// ===== design/hst_mem.sv =====
module hst_mem #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned IW    = 6
) (
  input  logic          clk_i,
  input  logic          rd_en_i,
  input  logic [IW-1:0] rd_addr_a_i,
  input  logic [IW-1:0] rd_addr_b_i,
  output logic [31:0]   rd_data_a_o,
  output logic [31:0]   rd_data_b_o,
  input  logic          wr_en_i,
  input  logic [IW-1:0] wr_addr_i,
  input  logic [31:0]   wr_data_i
);

  logic [31:0] mem_q [DEPTH];
  logic [31:0] rd_a_q;
  logic [31:0] rd_b_q;

  // handle storage, two registered read ports and one write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_a_q <= mem_q[rd_addr_a_i];
      rd_b_q <= mem_q[rd_addr_b_i];
    end
  end

  assign rd_data_a_o = rd_a_q;
  assign rd_data_b_o = rd_b_q;

endmodule

// ===== design/hst_alloc.sv =====
module hst_alloc #(
  parameter int unsigned SLOTS = 64,
  parameter int unsigned IW    = 6
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          snap_i,
  input  logic          set_i,
  input  logic          clr_i,
  input  logic [IW-1:0] wr_idx_i,
  input  logic [IW-1:0] rd_idx_a_i,
  input  logic [IW-1:0] rd_idx_b_i,
  output logic          used_a_o,
  output logic          used_b_o,
  output logic          full_o,
  output logic [IW-1:0] free_idx_o
);
  import hst_pkg::*;

  localparam int unsigned NGRP = (SLOTS + GRP - 1) / GRP;
  localparam int unsigned GW   = (NGRP > 1) ? $clog2(NGRP) : 1;
  localparam int unsigned PADW = NGRP * GRP;
  localparam int unsigned FW   = GW + GRP_W;

  logic [SLOTS-1:0] used_q;
  logic [PADW-1:0]  padded;
  logic [GW-1:0]    grp_d, grp_q;
  logic             any_d, full_q;
  logic [GRP-1:0]   grp_bits;
  logic [GRP_W-1:0] bit_sel;
  logic [FW-1:0]    free_full;

  // in-use flags, cleared at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
    end else if (set_i) begin
      used_q[wr_idx_i] <= 1'b1;
    end else if (clr_i) begin
      used_q[wr_idx_i] <= 1'b0;
    end
  end

  // slots past the end count as occupied
  if (PADW > SLOTS) begin : g_pad
    assign padded = {{(PADW - SLOTS){1'b1}}, used_q};
  end else begin : g_nopad
    assign padded = used_q;
  end

  // first stage: lowest group with a free slot
  always_comb begin
    grp_d = '0;
    any_d = 1'b0;
    for (int g = NGRP - 1; g >= 0; g--) begin
      if (!(&padded[g*GRP +: GRP])) begin
        grp_d = GW'(g);
        any_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grp_q  <= '0;
      full_q <= 1'b1;
    end else if (snap_i) begin
      grp_q  <= grp_d;
      full_q <= !any_d;
    end
  end

  // second stage: lowest free slot inside the chosen group
  assign grp_bits = padded[grp_q*GRP +: GRP];

  always_comb begin
    bit_sel = '0;
    for (int i = GRP - 1; i >= 0; i--) begin
      if (!grp_bits[i]) begin
        bit_sel = GRP_W'(i);
      end
    end
  end

  assign free_full  = {grp_q, bit_sel};
  assign free_idx_o = free_full[IW-1:0];
  assign full_o     = full_q;
  assign used_a_o   = used_q[rd_idx_a_i];
  assign used_b_o   = used_q[rd_idx_b_i];

endmodule

// ===== design/handle_slot_table_top.sv =====
// Descriptor slot table with lowest-free allocation. Every request passes
// an accept cycle and then the execute state: in the accept cycle the
// handle memory is read at the source and destination slots and the lowest
// slot group with a free entry is latched; in the execute state the lowest
// free slot within that group is found, the handle memory and in-use flags
// are written back and the result is loaded into the output register. This
// split is set by the registered read of the handle memory. A request that
// finishes while the previous result is still unclaimed waits in the execute
// state. In-use flags are flip-flops cleared by reset, so the table is
// usable right after reset with no clearing pass.
module handle_slot_table_top #(
  parameter int unsigned SLOTS = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  hst_pkg::req_t in_req_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output hst_pkg::rsp_t out_rsp_o
);
  import hst_pkg::*;

  localparam int unsigned IW = $clog2(SLOTS);
  localparam int unsigned OW = $clog2(SLOTS + 1);
  localparam logic [8:0]  SlotsW = 9'(SLOTS);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic          state_q, state_d;
  req_t          req_q;
  rsp_t          rsp_q, rsp;
  logic          out_valid_q;
  logic [OW-1:0] occ_q, occ_next;
  logic          accept, fire;

  logic [7:0]    dst_in;
  logic [IW-1:0] a_idx, dst_idx, free_idx, wr_idx;
  logic [7:0]    dst8;
  logic [31:0]   rd_a, rd_b, src, obj, wr_data;
  logic          used_a, used_b, full;
  logic          a_ok, dst_rng;
  logic          set_en, clr_en, wr_en, occ_inc, occ_dec;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign fire       = (state_q == ST_EXEC) && (!out_valid_q || out_ready_i);

  // destination slot of the incoming request
  assign dst_in = (in_req_i.opcode == OP_DUP2) ? in_req_i.index_b : in_req_i.index_a;

  hst_mem #(
    .DEPTH(SLOTS),
    .IW   (IW)
  ) u_mem (
    .clk_i      (clk_i),
    .rd_en_i    (accept),
    .rd_addr_a_i(in_req_i.index_a[IW-1:0]),
    .rd_addr_b_i(dst_in[IW-1:0]),
    .rd_data_a_o(rd_a),
    .rd_data_b_o(rd_b),
    .wr_en_i    (wr_en && fire),
    .wr_addr_i  (wr_idx),
    .wr_data_i  (wr_data)
  );

  hst_alloc #(
    .SLOTS(SLOTS),
    .IW   (IW)
  ) u_alloc (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .snap_i    (accept),
    .set_i     (set_en && fire),
    .clr_i     (clr_en && fire),
    .wr_idx_i  (wr_idx),
    .rd_idx_a_i(a_idx),
    .rd_idx_b_i(dst_idx),
    .used_a_o  (used_a),
    .used_b_o  (used_b),
    .full_o    (full),
    .free_idx_o(free_idx)
  );

  // operand decode for the request in flight
  assign dst8    = (req_q.opcode == OP_DUP2) ? req_q.index_b : req_q.index_a;
  assign a_idx   = req_q.index_a[IW-1:0];
  assign dst_idx = dst8[IW-1:0];
  assign a_ok    = ({1'b0, req_q.index_a} < SlotsW) && used_a;
  assign dst_rng = ({1'b0, dst8} < SlotsW);
  assign src     = a_ok ? rd_a : 32'd0;
  assign obj     = (req_q.opcode == OP_DUP || req_q.opcode == OP_DUP2) ?
                   src : req_q.object_handle;

  // operation result and write-back
  always_comb begin
    rsp     = '0;
    set_en  = 1'b0;
    clr_en  = 1'b0;
    wr_en   = 1'b0;
    wr_idx  = dst_idx;
    wr_data = obj;
    occ_inc = 1'b0;
    occ_dec = 1'b0;
    case (req_q.opcode)
      OP_ALLOC_REF, OP_INSTALL_TAKE, OP_DUP: begin
        if ((req_q.opcode == OP_DUP && !a_ok) || obj == 32'd0) begin
          rsp.status = STATUS_INVALID;
        end else if (full) begin
          rsp.status = STATUS_TOO_MANY;
        end else begin
          set_en         = 1'b1;
          wr_en          = 1'b1;
          wr_idx         = free_idx;
          occ_inc        = 1'b1;
          rsp.slot_index = 8'(free_idx);
          if (req_q.opcode != OP_INSTALL_TAKE) begin
            rsp.ref_handle = obj;
          end
        end
      end
      OP_INSTALL_AT, OP_DUP2: begin
        if ((req_q.opcode == OP_DUP2 && !a_ok) || obj == 32'd0 || !dst_rng) begin
          rsp.status = STATUS_INVALID;
        end else begin
          rsp.slot_index = dst8;
          if (!(req_q.opcode == OP_DUP2 && dst8 == req_q.index_a)) begin
            if (used_b) begin
              rsp.unref_handle = rd_b;
            end else begin
              set_en  = 1'b1;
              occ_inc = 1'b1;
            end
            wr_en          = 1'b1;
            rsp.ref_handle = obj;
          end
        end
      end
      OP_GET: begin
        if (!a_ok) begin
          rsp.status = STATUS_INVALID;
        end else begin
          rsp.slot_index   = req_q.index_a;
          rsp.found_handle = src;
        end
      end
      OP_CLOSE: begin
        if (!a_ok) begin
          rsp.status = STATUS_INVALID;
        end else begin
          rsp.unref_handle = src;
          clr_en           = 1'b1;
          wr_idx           = a_idx;
          occ_dec          = 1'b1;
          rsp.slot_index   = req_q.index_a;
        end
      end
      OP_COUNT: begin
      end
      default: begin
      end
    endcase
    occ_next       = occ_q + OW'(occ_inc) - OW'(occ_dec);
    rsp.open_count = 9'(occ_next);
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (fire) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      occ_q       <= '0;
    end else begin
      state_q <= state_d;
      if (fire) begin
        out_valid_q <= 1'b1;
        occ_q       <= occ_next;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // request and result holding registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= in_req_i;
    end
    if (fire) begin
      rsp_q <= rsp;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = rsp_q;

  // occupancy never exceeds the table size
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({{(32 - OW){1'b0}}, occ_q} <= SLOTS))
    else $error("occupancy above table size");

  // a full-table status only when every slot is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_rsp_o.status == STATUS_TOO_MANY) |->
    (out_rsp_o.open_count == SlotsW))
    else $error("too-many status with free slots");

  // a successful result names a slot inside the table
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_rsp_o.status == STATUS_OK) |->
    ({1'b0, out_rsp_o.slot_index} < SlotsW))
    else $error("slot index out of range");

  // an accepted request is always in the execute state in the following cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == ST_EXEC))
    else $error("accepted request not executed");

endmodule

// ===== bench/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import hst_pkg::*;

  localparam int unsigned SLOTS       = 64;
  localparam int unsigned CYCLE_LIMIT = 200_000;
  localparam int unsigned HOLD_CYCLES = 300;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  req_t in_req_i;
  logic out_valid_o;
  logic out_ready_i;
  rsp_t out_rsp_o;

  // shadow copy of the table
  logic        slot_used [SLOTS];
  logic [31:0] slot_obj  [SLOTS];
  int unsigned open_slots;
  int unsigned peak_open;

  rsp_t        expected_rsps [$];
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned hold_off_left;
  int unsigned requests_sent;
  int unsigned results_seen;
  int unsigned status_seen [3];
  int unsigned mismatches;
  int unsigned cycle_count;

  handle_slot_table_top #(
    .SLOTS(SLOTS)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_rsp_o  (out_rsp_o)
  );

  // clock
  always #10 clk_i = ~clk_i;

  // run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_count,
               expected_rsps.size());
      $display("status: fail");
      $finish;
    end
  end

  // result side: long hold-off first, otherwise random stalls
  always @(negedge clk_i) begin
    if (hold_off_left != 0) begin
      hold_off_left = hold_off_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // lowest free slot, SLOTS when full
  function automatic int unsigned lowest_free_slot();
    for (int unsigned i = 0; i < SLOTS; i++)
      if (!slot_used[i]) return i;
    return SLOTS;
  endfunction

  // apply one request to the shadow table and return its result
  function automatic rsp_t apply_table_op(input req_t r);
    rsp_t        rsp;
    logic        src_ok;
    logic [31:0] src_obj;
    logic [31:0] obj;
    int unsigned dst;
    int unsigned free_slot;
    rsp        = '0;
    rsp.status = STATUS_OK;
    src_ok     = (r.index_a < SLOTS) && slot_used[r.index_a];
    src_obj    = src_ok ? slot_obj[r.index_a] : '0;
    case (r.opcode)
      OP_ALLOC_REF, OP_INSTALL_TAKE, OP_DUP: begin
        obj       = (r.opcode == OP_DUP) ? src_obj : r.object_handle;
        free_slot = lowest_free_slot();
        if ((r.opcode == OP_DUP && !src_ok) || obj == '0) begin
          rsp.status = STATUS_INVALID;
        end else if (free_slot >= SLOTS) begin
          rsp.status = STATUS_TOO_MANY;
        end else begin
          slot_used[free_slot] = 1'b1;
          slot_obj[free_slot]  = obj;
          open_slots++;
          rsp.slot_index = 8'(free_slot);
          if (r.opcode != OP_INSTALL_TAKE) rsp.ref_handle = obj;
        end
      end
      OP_INSTALL_AT, OP_DUP2: begin
        dst = (r.opcode == OP_DUP2) ? r.index_b : r.index_a;
        obj = (r.opcode == OP_DUP2) ? src_obj : r.object_handle;
        if ((r.opcode == OP_DUP2 && !src_ok) || obj == '0 || dst >= SLOTS) begin
          rsp.status = STATUS_INVALID;
        end else begin
          rsp.slot_index = 8'(dst);
          // dup2 onto its own slot changes nothing
          if (!(r.opcode == OP_DUP2 && dst == r.index_a)) begin
            if (slot_used[dst]) begin
              rsp.unref_handle = slot_obj[dst];
            end else begin
              slot_used[dst] = 1'b1;
              open_slots++;
            end
            slot_obj[dst]  = obj;
            rsp.ref_handle = obj;
          end
        end
      end
      OP_GET: begin
        if (!src_ok) begin
          rsp.status = STATUS_INVALID;
        end else begin
          rsp.slot_index   = r.index_a;
          rsp.found_handle = src_obj;
        end
      end
      OP_CLOSE: begin
        if (!src_ok) begin
          rsp.status = STATUS_INVALID;
        end else begin
          slot_used[r.index_a] = 1'b0;
          slot_obj[r.index_a]  = '0;
          open_slots--;
          rsp.slot_index   = r.index_a;
          rsp.unref_handle = src_obj;
        end
      end
      default: begin
      end
    endcase
    rsp.open_count = 9'(open_slots);
    if (open_slots > peak_open) peak_open = open_slots;
    return rsp;
  endfunction

  function automatic req_t mk_req(input logic [2:0] op, input logic [31:0] obj,
                                  input logic [7:0] a, input logic [7:0] b);
    req_t r;
    r.opcode        = op;
    r.object_handle = obj;
    r.index_a       = a;
    r.index_b       = b;
    return r;
  endfunction

  // random occupied slot, or any valid slot when the table is empty
  function automatic int unsigned random_used_slot();
    int unsigned start;
    start = $urandom_range(0, SLOTS - 1);
    for (int unsigned i = 0; i < SLOTS; i++)
      if (slot_used[(start + i) % SLOTS]) return (start + i) % SLOTS;
    return start;
  endfunction

  function automatic logic [7:0] pick_index();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 75 && open_slots != 0) return 8'(random_used_slot());
    if (roll < 90) return 8'($urandom_range(0, SLOTS - 1));
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [31:0] random_handle();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 5) return '0;
    if (roll < 10) return 32'hFFFF_FFFF;
    return $urandom();
  endfunction

  // mostly legal requests on live slots, some null handles and bad indexes
  function automatic req_t random_request();
    req_t        r;
    int unsigned grow_pct;
    int unsigned roll;
    r.object_handle = random_handle();
    r.index_a       = pick_index();
    r.index_b       = 8'($urandom_range(0, 255));
    grow_pct = (open_slots > 48) ? 25 : (open_slots < 12) ? 75 : 50;
    if ($urandom_range(0, 99) < grow_pct) begin
      case ($urandom_range(0, 3))
        0:       r.opcode = OP_ALLOC_REF;
        1:       r.opcode = OP_INSTALL_TAKE;
        2:       r.opcode = OP_INSTALL_AT;
        default: r.opcode = OP_DUP;
      endcase
    end else begin
      case ($urandom_range(0, 4))
        0:       r.opcode = OP_GET;
        1, 2:    r.opcode = OP_CLOSE;
        3:       r.opcode = OP_DUP2;
        default: r.opcode = OP_COUNT;
      endcase
    end
    // dup2 destination: itself, a live slot, any slot or out of range
    if (r.opcode == OP_DUP2) begin
      roll = $urandom_range(0, 99);
      if (roll < 10) r.index_b = r.index_a;
      else if (roll < 55) r.index_b = 8'(random_used_slot());
      else if (roll < 90) r.index_b = 8'($urandom_range(0, SLOTS - 1));
    end
    return r;
  endfunction

  // send one request, called and returning at a falling edge
  task automatic send_request(input req_t r);
    if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= r;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    expected_rsps.push_back(apply_table_op(r));
    requests_sent++;
    @(negedge clk_i);
  endtask

  // stop sending and wait for every pending result
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (expected_rsps.size() != 0) @(negedge clk_i);
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch at result %0d: %s got 0x%0h expected 0x%0h", results_seen, what,
             got, want);
    mismatches++;
  endtask

  // result checker
  always @(posedge clk_i) begin
    rsp_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (expected_rsps.size() == 0) begin
        report_mismatch("unexpected result, status", 32'(out_rsp_o.status), '0);
      end else begin
        want = expected_rsps.pop_front();
        if (out_rsp_o.status < 3) status_seen[out_rsp_o.status]++;
        if (out_rsp_o.status !== want.status)
          report_mismatch("status", 32'(out_rsp_o.status), 32'(want.status));
        if (out_rsp_o.slot_index !== want.slot_index)
          report_mismatch("slot_index", 32'(out_rsp_o.slot_index), 32'(want.slot_index));
        if (out_rsp_o.found_handle !== want.found_handle)
          report_mismatch("found_handle", out_rsp_o.found_handle, want.found_handle);
        if (out_rsp_o.open_count !== want.open_count)
          report_mismatch("open_count", 32'(out_rsp_o.open_count), 32'(want.open_count));
        if (out_rsp_o.ref_handle !== want.ref_handle)
          report_mismatch("ref_handle", out_rsp_o.ref_handle, want.ref_handle);
        if (out_rsp_o.unref_handle !== want.unref_handle)
          report_mismatch("unref_handle", out_rsp_o.unref_handle, want.unref_handle);
      end
    end
  end

  // edge cases on a fresh table: null handle, bad index, unused slot, dup2 onto itself
  task automatic test_directed();
    send_request(mk_req(OP_COUNT,        32'h0,         8'd0,   8'd0));
    send_request(mk_req(OP_GET,          32'h0,         8'd0,   8'd0));
    send_request(mk_req(OP_CLOSE,        32'h0,         8'd0,   8'd0));
    send_request(mk_req(OP_DUP,          32'h0,         8'd0,   8'd0));
    send_request(mk_req(OP_DUP2,         32'h0,         8'd0,   8'd1));
    send_request(mk_req(OP_ALLOC_REF,    32'h0,         8'd0,   8'd0));
    send_request(mk_req(OP_ALLOC_REF,    32'hFFFF_FFFF, 8'd0,   8'd0));
    send_request(mk_req(OP_INSTALL_TAKE, 32'h0000_0001, 8'd0,   8'd0));
    send_request(mk_req(OP_INSTALL_AT,   32'hA5A5_A5A5, 8'd63,  8'd0));
    send_request(mk_req(OP_INSTALL_AT,   32'h1234_5678, 8'd64,  8'd0));
    send_request(mk_req(OP_INSTALL_AT,   32'h1234_5678, 8'd255, 8'd0));
    send_request(mk_req(OP_INSTALL_AT,   32'h0,         8'd5,   8'd0));
    send_request(mk_req(OP_INSTALL_AT,   32'hDEAD_BEEF, 8'd0,   8'd0));
    send_request(mk_req(OP_GET,          32'h0,         8'd63,  8'd0));
    send_request(mk_req(OP_GET,          32'h0,         8'd200, 8'd0));
    send_request(mk_req(OP_DUP,          32'h0,         8'd1,   8'd0));
    send_request(mk_req(OP_DUP,          32'h0,         8'd255, 8'd0));
    send_request(mk_req(OP_DUP2,         32'h0,         8'd1,   8'd1));
    send_request(mk_req(OP_DUP2,         32'h0,         8'd1,   8'd63));
    send_request(mk_req(OP_DUP2,         32'h0,         8'd0,   8'd5));
    send_request(mk_req(OP_DUP2,         32'h0,         8'd0,   8'd64));
    send_request(mk_req(OP_DUP2,         32'h0,         8'd255, 8'd3));
    send_request(mk_req(OP_CLOSE,        32'h0,         8'd1,   8'd0));
    send_request(mk_req(OP_CLOSE,        32'h0,         8'd255, 8'd0));
    send_request(mk_req(OP_COUNT,        32'h0,         8'd0,   8'd0));
    drain_results();
  endtask

  // fill every slot, hit the full-table cases, then free most of it again
  task automatic test_full_table();
    req_t r;
    send_idle_pct  = 68;
    recv_stall_pct = 0;
    while (open_slots < SLOTS) begin
      r = random_request();
      r.object_handle = $urandom() | 32'h0000_0100;
      case ($urandom_range(0, 2))
        0:       r.opcode = OP_ALLOC_REF;
        1:       r.opcode = OP_INSTALL_TAKE;
        default: begin
          r.opcode  = OP_DUP;
          r.index_a = 8'(random_used_slot());
        end
      endcase
      send_request(r);
    end
    send_request(mk_req(OP_ALLOC_REF,    $urandom() | 32'h1, 8'd0, 8'd0));
    send_request(mk_req(OP_INSTALL_TAKE, $urandom() | 32'h1, 8'd0, 8'd0));
    send_request(mk_req(OP_DUP,          32'h0, 8'(random_used_slot()), 8'd0));
    send_request(mk_req(OP_INSTALL_AT,   $urandom() | 32'h1, 8'd63, 8'd0));
    send_request(mk_req(OP_DUP2,         32'h0, 8'd63, 8'd0));
    send_request(mk_req(OP_COUNT,        32'h0, 8'd0, 8'd0));
    while (open_slots > 24) begin
      r = random_request();
      r.opcode  = ($urandom_range(0, 3) == 0) ? OP_GET : OP_CLOSE;
      r.index_a = 8'(random_used_slot());
      send_request(r);
    end
    drain_results();
  endtask

  // random traffic under one idle and one stall setting
  task automatic test_random_traffic(input int unsigned idle_pct,
                                     input int unsigned stall_pct, input int unsigned count);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (count) send_request(random_request());
    drain_results();
  endtask

  // result side held off while requests keep coming, so the input stalls
  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_off_left  = HOLD_CYCLES;
    repeat (24) send_request(random_request());
    drain_results();
  endtask

  initial begin
    clk_i          = 1'b0;
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    in_req_i       = '0;
    out_ready_i    = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_off_left  = 0;
    requests_sent  = 0;
    results_seen   = 0;
    mismatches     = 0;
    cycle_count    = 0;
    open_slots     = 0;
    peak_open      = 0;
    status_seen    = '{default: 0};
    for (int unsigned i = 0; i < SLOTS; i++) begin
      slot_used[i] = 1'b0;
      slot_obj[i]  = '0;
    end

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed();
    test_full_table();
    test_random_traffic(0, 0, 70);
    test_random_traffic(68, 0, 70);
    test_random_traffic(0, 68, 70);
    test_random_traffic(7, 7, 70);
    test_backpressure();

    // pipeline tail
    repeat (20) @(negedge clk_i);
    if (expected_rsps.size() != 0)
      report_mismatch("results never returned", 32'(expected_rsps.size()), '0);

    $display("%0d requests, %0d results: %0d ok, %0d invalid, %0d too many",
             requests_sent, results_seen, status_seen[STATUS_OK],
             status_seen[STATUS_INVALID], status_seen[STATUS_TOO_MANY]);
    $display("peak occupancy %0d of %0d slots, %0d mismatches", peak_open, SLOTS,
             mismatches);
    if (mismatches == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule

// ===== sim.f =====
design/hst_pkg.sv
design/hst_mem.sv
design/hst_alloc.sv
design/handle_slot_table_top.sv
bench/tb_top.sv
